FILE: sv/dpm_pkg.sv
// Shared types, constants and mode decoding for the fixed-point dot-product MAC.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dpm_pkg;

  localparam int unsigned FUNC_W   = 4;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned EXT_W    = ACC_W + 2;

  localparam logic signed [EXT_W-1:0] SAT31_MAX = 34'sh0_3fff_ffff;
  localparam logic signed [EXT_W-1:0] SAT31_MIN = 34'sh3_c000_0000;
  localparam logic signed [EXT_W-1:0] SAT32_MAX = 34'sh0_7fff_ffff;
  localparam logic signed [EXT_W-1:0] SAT32_MIN = 34'sh3_8000_0000;

  typedef enum logic [FUNC_W-1:0] {
    MODE_ADD            = 4'd0,
    MODE_SUB            = 4'd1,
    MODE_ADD_SAT31      = 4'd2,
    MODE_SUB_SAT31      = 4'd3,
    MODE_ADD_HALF       = 4'd4,
    MODE_SUB_HALF       = 4'd5,
    MODE_ADD_HALF_SAT31 = 4'd6,
    MODE_SUB_HALF_SAT31 = 4'd7,
    MODE_ADD_HALF_SAT32 = 4'd8
  } mode_t;

  typedef struct packed {
    logic sub;
    logic sat31;
    logic sat32;
    logic half;
  } mode_ctl_t;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [FUNC_W-1:0] func;
  } item_ctl_t;

  function automatic mode_ctl_t decode_mode(input logic [FUNC_W-1:0] func);
    mode_ctl_t c;
    c = '0;
    case (func)
      MODE_ADD: begin
      end
      MODE_SUB: begin
        c.sub = 1'b1;
      end
      MODE_ADD_SAT31: begin
        c.sat31 = 1'b1;
      end
      MODE_SUB_SAT31: begin
        c.sub   = 1'b1;
        c.sat31 = 1'b1;
      end
      MODE_ADD_HALF: begin
        c.half = 1'b1;
      end
      MODE_SUB_HALF: begin
        c.sub  = 1'b1;
        c.half = 1'b1;
      end
      MODE_ADD_HALF_SAT31: begin
        c.sat31 = 1'b1;
        c.half  = 1'b1;
      end
      MODE_SUB_HALF_SAT31: begin
        c.sub   = 1'b1;
        c.sat31 = 1'b1;
        c.half  = 1'b1;
      end
      MODE_ADD_HALF_SAT32: begin
        c.sat32 = 1'b1;
        c.half  = 1'b1;
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/dpm_prod_stage.sv
// Input register and product register of the dot-product MAC, with their handshake.
// Depends on dpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpm_prod_stage (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic        [dpm_pkg::FUNC_W-1:0]   in_func,
  input  wire logic                                in_first,
  input  wire logic                                in_last,
  input  wire logic signed [dpm_pkg::ACC_W-1:0]    in_start_value,
  input  wire logic signed [dpm_pkg::SAMPLE_W-1:0] in_sample_a,
  input  wire logic signed [dpm_pkg::SAMPLE_W-1:0] in_sample_b,
  input  wire logic                                acc_take,
  output dpm_pkg::item_ctl_t                       prod_ctl,
  output logic signed [dpm_pkg::PROD_W-1:0]        prod_value,
  output logic signed [dpm_pkg::ACC_W-1:0]         prod_start
);
  import dpm_pkg::*;

  item_ctl_t                  s1_ctl_r;
  item_ctl_t                  s1_ctl_nxt;
  logic signed [ACC_W-1:0]    s1_start_r;
  logic signed [SAMPLE_W-1:0] s1_a_r;
  logic signed [SAMPLE_W-1:0] s1_b_r;
  item_ctl_t                  s2_ctl_r;
  item_ctl_t                  s2_ctl_nxt;
  logic signed [PROD_W-1:0]   s2_prod_r;
  logic signed [PROD_W-1:0]   s2_prod_nxt;
  logic signed [ACC_W-1:0]    s2_start_r;
  logic                       s1_free;
  logic                       s2_free;

  assign s2_free  = !s2_ctl_r.valid || acc_take;
  assign s1_free  = !s1_ctl_r.valid || s2_free;
  assign in_stall = !s1_free;

  always_comb begin
    s1_ctl_nxt = s1_ctl_r;
    if (s1_free) begin
      s1_ctl_nxt.valid = in_valid;
      s1_ctl_nxt.first = in_first;
      s1_ctl_nxt.last  = in_last;
      s1_ctl_nxt.func  = in_func;
    end
    s2_ctl_nxt = s2_ctl_r;
    if (s2_free) begin
      s2_ctl_nxt = s1_ctl_r;
    end
    s2_prod_nxt = PROD_W'(s1_a_r) * PROD_W'(s1_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
      s2_ctl_r <= s2_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_start_r <= in_start_value;
      s1_a_r     <= in_sample_a;
      s1_b_r     <= in_sample_b;
    end
    if (s2_free) begin
      s2_prod_r  <= s2_prod_nxt;
      s2_start_r <= s1_start_r;
    end
  end

  assign prod_ctl   = s2_ctl_r;
  assign prod_value = s2_prod_r;
  assign prod_start = s2_start_r;

endmodule

`default_nettype wire

FILE: sv/dpm_accum.sv
// Accumulator, held mode and result register of the dot-product MAC.
// Depends on dpm_pkg for the mode decoder and the clamp limits.
`timescale 1ns / 1ps
`default_nettype none

module dpm_accum (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire dpm_pkg::item_ctl_t                  prod_ctl,
  input  wire logic signed [dpm_pkg::PROD_W-1:0]   prod_value,
  input  wire logic signed [dpm_pkg::ACC_W-1:0]    prod_start,
  output logic                                     acc_take,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [dpm_pkg::ACC_W-1:0]         out_result
);
  import dpm_pkg::*;

  logic signed [ACC_W-1:0] sum_r;
  logic signed [ACC_W-1:0] sum_nxt;
  logic [FUNC_W-1:0]       mode_r;
  logic [FUNC_W-1:0]       mode_sel;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [ACC_W-1:0] out_result_r;
  logic signed [ACC_W-1:0] out_result_nxt;
  logic signed [ACC_W-1:0] base;
  logic signed [EXT_W-1:0] base_ext;
  logic signed [EXT_W-1:0] prod_ext;
  logic signed [EXT_W-1:0] raw_sum;
  logic signed [EXT_W-1:0] clamped;
  mode_ctl_t               ctl;
  logic                    out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign acc_take = prod_ctl.valid && (!prod_ctl.last || out_free);

  always_comb begin
    if (prod_ctl.first) begin
      base     = {prod_start[ACC_W-1], prod_start[ACC_W-1:1]};
      mode_sel = prod_ctl.func;
    end else begin
      base     = sum_r;
      mode_sel = mode_r;
    end
    ctl      = decode_mode(mode_sel);
    base_ext = EXT_W'(base);
    prod_ext = EXT_W'(prod_value);
    raw_sum  = ctl.sub ? (base_ext - prod_ext) : (base_ext + prod_ext);
    clamped  = raw_sum;
    if (ctl.sat31) begin
      if (raw_sum > SAT31_MAX) begin
        clamped = SAT31_MAX;
      end else if (raw_sum < SAT31_MIN) begin
        clamped = SAT31_MIN;
      end
    end else if (ctl.sat32) begin
      if (raw_sum > SAT32_MAX) begin
        clamped = SAT32_MAX;
      end else if (raw_sum < SAT32_MIN) begin
        clamped = SAT32_MIN;
      end
    end
    sum_nxt        = clamped[ACC_W-1:0];
    out_result_nxt = ctl.half ? sum_nxt : {sum_nxt[ACC_W-2:0], 1'b0};

    out_valid_nxt = out_valid_r;
    if (acc_take && prod_ctl.last) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      mode_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc_take) begin
        sum_r  <= sum_nxt;
        mode_r <= mode_sel;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_take && prod_ctl.last) begin
      out_result_r <= out_result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire

FILE: sv/fixed_point_dot_product_mac.sv
// Top level of the fixed-point dot-product MAC: product stage and accumulator.
// Depends on dpm_pkg, dpm_prod_stage and dpm_accum.
//
// Each input request carries one pair of signed 16-bit samples. A request with
// first set loads the accumulator with start_value shifted right by one and
// latches func as the mode; every request then adds or subtracts the product
// of its pair, wrapping or clamping as the mode says. A request with last set
// produces one output request holding the final sum, doubled in the full
// modes and unchanged in the half modes. Other requests produce no output.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low.
// The last request passes the input register and the product register; the
// result register loads when the accumulator takes it. Throughput: one request
// per cycle while in_stall is low; the accumulator add-and-clamp is combinational.
// While the receiver stalls, the result waits in the output register and
// requests without last keep flowing; only a second last request waits, and
// in_stall rises once the pipeline behind it is full.
// Reset clears the accumulator, the held mode and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_dot_product_mac (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic        [dpm_pkg::FUNC_W-1:0]   in_func,
  input  wire logic                                in_first,
  input  wire logic                                in_last,
  input  wire logic signed [dpm_pkg::ACC_W-1:0]    in_start_value,
  input  wire logic signed [dpm_pkg::SAMPLE_W-1:0] in_sample_a,
  input  wire logic signed [dpm_pkg::SAMPLE_W-1:0] in_sample_b,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [dpm_pkg::ACC_W-1:0]         out_result
);
  import dpm_pkg::*;

  item_ctl_t               prod_ctl;
  logic signed [PROD_W-1:0] prod_value;
  logic signed [ACC_W-1:0]  prod_start;
  logic                     acc_take;

  dpm_prod_stage u_prod (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_first       (in_first),
    .in_last        (in_last),
    .in_start_value (in_start_value),
    .in_sample_a    (in_sample_a),
    .in_sample_b    (in_sample_b),
    .acc_take       (acc_take),
    .prod_ctl       (prod_ctl),
    .prod_value     (prod_value),
    .prod_start     (prod_start)
  );

  dpm_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod_ctl   (prod_ctl),
    .prod_value (prod_value),
    .prod_start (prod_start),
    .acc_take   (acc_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

endmodule

`default_nettype wire

FILE: sv/dpm_checker.sv
// Port-level checks for the fixed-point dot-product MAC, bound to its top level.
// Depends on dpm_pkg and fixed_point_dot_product_mac.
`timescale 1ns / 1ps
`default_nettype none

module dpm_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic signed [dpm_pkg::ACC_W-1:0] out_result
);
  import dpm_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while the output side is free");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_result))
    else $error("result changed while stalled");

endmodule

bind fixed_point_dot_product_mac dpm_checker u_dpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_result (out_result)
);

`default_nettype wire
